// ===== src/mgt_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked grid triangulator package
// Shared widths, the quad record passed from front to back, and the
// configuration register map.
// ----------------------------------------------------------------------------
package mgt_pkg;

	// Fixed field widths.
	localparam int STEPS_W   = 12;
	localparam int RADIAL_W  = 8;
	localparam int IDX_W     = 19;
	localparam int CFG_IDX_W = 3;

	// Lower bounds that the geometry registers saturate to.
	localparam int MIN_STEPS  = 2;
	localparam int MIN_RADIAL = 8;

	// Number of kept quads that can wait between front and back.
	localparam int QUEUE_DEPTH = 4;

	typedef logic [IDX_W-1:0] vidx_t;

	// One kept quad: its lower-right index d and its upper-right index b.
	// The other two corners are one less than these.
	typedef struct packed {
		vidx_t d_idx;
		vidx_t b_idx;
	} quad_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEPS    = 3'd0,
		REG_RADIAL   = 3'd1,
		REG_AVG_THR  = 3'd2,
		REG_MAX_THR  = 3'd3,
		REG_PART_THR = 3'd4
	} cfg_reg_t;

endpackage

// ===== src/mgt_front.sv =====
// ----------------------------------------------------------------------------
// Masked grid triangulator front end
// Accepts mask samples, tracks the grid position, keeps the previous row in a
// line store and decides for every completed quad whether it is kept.
// ----------------------------------------------------------------------------
module mgt_front import mgt_pkg::*; #(
	parameter int MAX_RADIAL     = 128,
	parameter int MAX_STEPS      = 2048,
	parameter int MASK_FRAC_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [MASK_FRAC_BITS:0] opening_mask,
	input  logic                    grid_start,
	input  logic [STEPS_W-1:0]      steps_cfg,
	input  logic [RADIAL_W-1:0]     radial_cfg,
	input  logic [MASK_FRAC_BITS:0] avg_thr,
	input  logic [MASK_FRAC_BITS:0] max_thr,
	input  logic [MASK_FRAC_BITS:0] part_thr,
	output logic                    push_valid,
	input  logic                    push_ready,
	output quad_t                   push_data
);

	localparam int MW    = MASK_FRAC_BITS + 1;
	localparam int SUMW  = MW + 2;
	localparam int DEPTH = MAX_RADIAL + 1;
	localparam int CW    = $clog2(MAX_RADIAL + 1);
	localparam int RCW   = (CW > RADIAL_W) ? CW : RADIAL_W;
	localparam int SCW   = ($clog2(MAX_STEPS + 2) > STEPS_W + 1) ?
		$clog2(MAX_STEPS + 2) : STEPS_W + 1;
	localparam logic [MW-1:0] MASK_ONE = {1'b1, {MASK_FRAC_BITS{1'b0}}};

	// Line store holding the previous row of masks.
	logic [MW-1:0] line_mem [DEPTH];

	logic [CW-1:0]      col_q;
	logic [STEPS_W-1:0] row_q;
	vidx_t              vcnt_q;
	logic [MW-1:0]      above_q;
	logic [MW-1:0]      left_q;

	logic               s1_v_q;
	logic [MW-1:0]      a_s1, c_s1, d_s1;
	vidx_t              didx_s1, bidx_s1;

	logic [RCW-1:0]     radial_ext;
	logic [CW-1:0]      radial_c;
	logic [SCW-1:0]     steps_ext, steps_c, steps_p1;
	logic [CW-1:0]      col_cnt_e, col;
	logic [STEPS_W-1:0] row_e, row_inc, row_next;
	vidx_t              vcnt_e, cols;
	logic [MW-1:0]      mask_sat;
	logic               accept, ignore, is_quad;
	logic [SUMW-1:0]    sum;
	logic [MW-1:0]      mx_ab, mx_cd, mx;
	logic               cull;

	// Saturate the geometry into its legal range.
	always_comb begin
		radial_ext = RCW'(radial_cfg);
		if (radial_ext < RCW'(MIN_RADIAL)) begin
			radial_c = CW'(MIN_RADIAL);
		end else if (radial_ext > RCW'(MAX_RADIAL)) begin
			radial_c = CW'(MAX_RADIAL);
		end else begin
			radial_c = radial_ext[CW-1:0];
		end
		steps_ext = SCW'(steps_cfg);
		if (steps_ext < SCW'(MIN_STEPS)) begin
			steps_c = SCW'(MIN_STEPS);
		end else if (steps_ext > SCW'(MAX_STEPS)) begin
			steps_c = SCW'(MAX_STEPS);
		end else begin
			steps_c = steps_ext;
		end
		steps_p1 = steps_c + SCW'(1);
	end

	// Position of the arriving vertex; a grid start clears the counters first.
	always_comb begin
		mask_sat  = (opening_mask > MASK_ONE) ? MASK_ONE : opening_mask;
		col_cnt_e = grid_start ? '0 : col_q;
		row_e     = grid_start ? '0 : row_q;
		vcnt_e    = grid_start ? '0 : vcnt_q;
		ignore    = SCW'(row_e) > steps_c;
		col       = (RCW'(col_cnt_e) > RCW'(radial_c)) ? radial_c : col_cnt_e;
		is_quad   = (row_e != '0) && (col != '0);
		cols      = IDX_W'(radial_c) + IDX_W'(1);
		row_inc   = row_e + STEPS_W'(1);
		row_next  = (SCW'(row_inc) > steps_p1) ? steps_p1[STEPS_W-1:0] : row_inc;
	end

	// Cull decision for the quad held in stage one. The upper-right corner is
	// the line store word read when this quad's last vertex was accepted.
	always_comb begin
		sum   = SUMW'(a_s1) + SUMW'(above_q) + SUMW'(c_s1) + SUMW'(d_s1);
		mx_ab = (a_s1 > above_q) ? a_s1 : above_q;
		mx_cd = (c_s1 > d_s1) ? c_s1 : d_s1;
		mx    = (mx_ab > mx_cd) ? mx_ab : mx_cd;
		cull  = (sum > {avg_thr, 2'b00}) ||
			((mx > max_thr) && (sum > {part_thr, 2'b00}));
	end

	assign push_valid        = s1_v_q && !cull;
	assign push_data.d_idx   = didx_s1;
	assign push_data.b_idx   = bidx_s1;
	assign in_ready          = !s1_v_q || cull || push_ready;
	assign accept            = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept && !ignore) begin
			line_mem[col] <= mask_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= '0;
			left_q  <= '0;
		end else if (accept && !ignore) begin
			above_q <= line_mem[col];
			left_q  <= mask_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vcnt_q <= '0;
		end else if (accept) begin
			if (ignore) begin
				col_q  <= col_cnt_e;
				row_q  <= row_e;
				vcnt_q <= vcnt_e;
			end else begin
				vcnt_q <= vcnt_e + IDX_W'(1);
				if (col >= radial_c) begin
					col_q <= '0;
					row_q <= row_next;
				end else begin
					col_q <= col + CW'(1);
					row_q <= row_e;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= !ignore && is_quad;
		end else if (in_ready) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1    <= above_q;
			c_s1    <= left_q;
			d_s1    <= mask_sat;
			didx_s1 <= vcnt_e;
			bidx_s1 <= vcnt_e - cols;
		end
	end

endmodule

// ===== src/mgt_queue.sv =====
// ----------------------------------------------------------------------------
// Masked grid triangulator quad queue
// A short first-in first-out buffer of kept quads between front and back.
// ----------------------------------------------------------------------------
module mgt_queue import mgt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  quad_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output quad_t pop_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	quad_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;

	assign push_ready = cnt_q != (PW+1)'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ===== src/mgt_back.sv =====
// ----------------------------------------------------------------------------
// Masked grid triangulator back end
// Takes one kept quad at a time and sends its six corner indices a, c, b,
// b, c, d through a registered output, one index per cycle while not stalled.
// ----------------------------------------------------------------------------
module mgt_back import mgt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pop_valid,
	output logic  pop_ready,
	input  quad_t pop_data,
	output logic  out_valid,
	input  logic  out_ready,
	output vidx_t vertex_index,
	output logic  last_of_quad
);

	typedef enum logic [5:0] {
		PH_A  = 6'b000001,
		PH_C1 = 6'b000010,
		PH_B1 = 6'b000100,
		PH_B2 = 6'b001000,
		PH_C2 = 6'b010000,
		PH_D  = 6'b100000
	} phase_t;

	phase_t ph_q, ph_next;
	quad_t  cur_q;
	logic   busy_q;
	logic   out_v_q, last_q;
	vidx_t  idx_q, idx_sel;
	logic   out_free, load_out, done;

	assign out_free  = !out_v_q || out_ready;
	assign load_out  = busy_q && out_free;
	assign done      = load_out && (ph_q == PH_D);
	assign pop_ready = !busy_q || done;

	always_comb begin
		case (ph_q)
			PH_A: begin
				idx_sel = cur_q.b_idx - IDX_W'(1);
				ph_next = PH_C1;
			end
			PH_C1: begin
				idx_sel = cur_q.d_idx - IDX_W'(1);
				ph_next = PH_B1;
			end
			PH_B1: begin
				idx_sel = cur_q.b_idx;
				ph_next = PH_B2;
			end
			PH_B2: begin
				idx_sel = cur_q.b_idx;
				ph_next = PH_C2;
			end
			PH_C2: begin
				idx_sel = cur_q.d_idx - IDX_W'(1);
				ph_next = PH_D;
			end
			PH_D: begin
				idx_sel = cur_q.d_idx;
				ph_next = PH_A;
			end
			default: begin
				idx_sel = cur_q.d_idx;
				ph_next = PH_A;
			end
		endcase
	end

	// A new quad always starts at the first corner; the last corner of the
	// previous quad already steps the phase back there.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			ph_q    <= PH_A;
			out_v_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
				ph_q   <= PH_A;
			end else begin
				if (load_out) begin
					ph_q <= ph_next;
				end
				if (done) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_data;
		end
		if (load_out) begin
			idx_q  <= idx_sel;
			last_q <= (ph_q == PH_D);
		end
	end

	assign out_valid    = out_v_q;
	assign vertex_index = idx_q;
	assign last_of_quad = last_q;

endmodule

// ===== src/masked_grid_triangulator_top.sv =====
// ----------------------------------------------------------------------------
// Masked grid triangulator
// Turns a row-major stream of per-vertex opening masks into the triangle
// index list of the grid quads that survive the mask cull.
// ----------------------------------------------------------------------------
// The block takes one mask request per grid vertex, row by row, over a grid of
// longitudinal_steps+1 rows by radial_segments+1 columns; grid_start marks the
// first vertex of a grid. Masks are unsigned with MASK_FRAC_BITS fraction bits
// and saturate to 1.0. When the lower-right corner of a quad arrives, the
// front end compares the corner sum and maximum against the three thresholds;
// a kept quad goes into a four-entry queue, and the back end sends its six
// indices a, c, b, b, c, d on the output, one per cycle unless out_ready
// stalls the output, with last_of_quad on the sixth. A vertex that keeps no
// quad (first row, first column, culled, or after the grid is complete)
// never holds up the input, so such vertices are accepted every cycle. A
// kept quad occupies the back end sequencer for all six of its indices, which
// limits the sustained rate when all quads are kept; the queue absorbs short
// runs of kept quads so the input keeps moving. A kept quad passes stage one,
// the queue and the back end's quad register on its way to the registered
// output. A new request is taken while an index still waits for out_ready.
// Configuration writes take effect at the next edge and are meant to be made
// while the block is idle. The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module masked_grid_triangulator_top import mgt_pkg::*; #(
	parameter int MAX_RADIAL     = 128,
	parameter int MAX_STEPS      = 2048,
	parameter int MASK_FRAC_BITS = 12,
	localparam int MW            = MASK_FRAC_BITS + 1,
	localparam int CFG_W         = (MW > STEPS_W) ? MW : STEPS_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [MASK_FRAC_BITS:0] opening_mask,
	input  logic                    grid_start,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [IDX_W-1:0]        vertex_index,
	output logic                    last_of_quad
);

	// Threshold reset values are 0.42, 0.74 and 0.28, rounded to the mask scale.
	localparam logic [MW-1:0] AVG_THR_RST  =
		MW'(((42 << MASK_FRAC_BITS) + 50) / 100);
	localparam logic [MW-1:0] MAX_THR_RST  =
		MW'(((74 << MASK_FRAC_BITS) + 50) / 100);
	localparam logic [MW-1:0] PART_THR_RST =
		MW'(((28 << MASK_FRAC_BITS) + 50) / 100);

	logic [STEPS_W-1:0]  steps_q;
	logic [RADIAL_W-1:0] radial_q;
	logic [MW-1:0]       avg_thr_q, max_thr_q, part_thr_q;

	logic  push_valid, push_ready, pop_valid, pop_ready;
	quad_t push_data, pop_data;

	// Configuration registers. Indices past the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q    <= STEPS_W'(16);
			radial_q   <= RADIAL_W'(8);
			avg_thr_q  <= AVG_THR_RST;
			max_thr_q  <= MAX_THR_RST;
			part_thr_q <= PART_THR_RST;
		end else if (cfg_write_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_STEPS:    steps_q    <= cfg_data[STEPS_W-1:0];
				REG_RADIAL:   radial_q   <= cfg_data[RADIAL_W-1:0];
				REG_AVG_THR:  avg_thr_q  <= cfg_data[MW-1:0];
				REG_MAX_THR:  max_thr_q  <= cfg_data[MW-1:0];
				REG_PART_THR: part_thr_q <= cfg_data[MW-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front end tracks the grid position, reads the line store and culls.
	mgt_front #(
		.MAX_RADIAL     (MAX_RADIAL),
		.MAX_STEPS      (MAX_STEPS),
		.MASK_FRAC_BITS (MASK_FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opening_mask (opening_mask),
		.grid_start   (grid_start),
		.steps_cfg    (steps_q),
		.radial_cfg   (radial_q),
		.avg_thr      (avg_thr_q),
		.max_thr      (max_thr_q),
		.part_thr     (part_thr_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	// Kept quads wait here so that front and back stall independently.
	mgt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The back end expands each quad into its six indices.
	mgt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vertex_index (vertex_index),
		.last_of_quad (last_of_quad)
	);

endmodule

// ===== src/mgt_checker.sv =====
// ----------------------------------------------------------------------------
// Masked grid triangulator output checker
// Watches the result port and checks the six-index pattern of every quad.
// ----------------------------------------------------------------------------
module mgt_port_props import mgt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [IDX_W-1:0] vertex_index,
	input logic             last_of_quad
);

	localparam logic [2:0] LAST_POS = 3'd5;
	localparam logic [2:0] B2_POS   = 3'd3;

	logic [2:0]       pos_q;
	logic [IDX_W-1:0] prev_idx_q;
	logic             out_acc;

	assign out_acc = out_valid && out_ready;

	// Position of the next request within its quad, and the last index taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			prev_idx_q <= '0;
		end else if (out_acc) begin
			pos_q      <= (pos_q == LAST_POS) ? 3'd0 : pos_q + 3'd1;
			prev_idx_q <= vertex_index;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		out_valid && $stable(vertex_index) && $stable(last_of_quad))
		else $error("output request changed while stalled");

	a_last_sixth: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (last_of_quad == (pos_q == LAST_POS)))
		else $error("last_of_quad not on the sixth index of a quad");

	a_b_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (pos_q == B2_POS) |-> (vertex_index == prev_idx_q))
		else $error("upper-right corner not repeated");

	a_d_follows_c: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (pos_q == LAST_POS) |->
		(vertex_index == prev_idx_q + IDX_W'(1)))
		else $error("lower-right corner does not follow lower-left");

endmodule

bind masked_grid_triangulator_top mgt_port_props u_mgt_port_props (.*);

// ===== verif/mgt_checker.sv =====
// ----------------------------------------------------------------------------
// Masked grid triangulator checker
// Watches the register port and both request channels, predicts the index
// stream of every accepted vertex and compares it with the indices that leave.
// ----------------------------------------------------------------------------
module mgt_checker import mgt_pkg::*; #(
	parameter int MAX_RADIAL     = 128,
	parameter int MAX_STEPS      = 2048,
	parameter int MASK_FRAC_BITS = 12,
	localparam int MW            = MASK_FRAC_BITS + 1,
	localparam int CFG_W         = (MW > STEPS_W) ? MW : STEPS_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [MW-1:0]        opening_mask,
	input  logic                 grid_start,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [IDX_W-1:0]     vertex_index,
	input  logic                 last_of_quad,
	input  logic                 wrap_up,
	output int                   outstanding,
	output int                   fail_count,
	output int                   kept_quads,
	output int                   culled_quads,
	output int                   ignored_vertices,
	output int                   indices_checked
);

	localparam int MASK_ONE        = 1 << MASK_FRAC_BITS;
	localparam int LSW             = $clog2(MAX_RADIAL + 1);
	localparam int STEPS_AT_RESET  = 16;
	localparam int RADIAL_AT_RESET = 8;
	localparam int AVG_AT_RESET    = 1720;
	localparam int MAX_AT_RESET    = 3031;
	localparam int PART_AT_RESET   = 1147;

	typedef struct packed {
		vidx_t idx;
		logic  last;
	} corner_t;

	corner_t expected_corners [$];
	corner_t want;

	// Register copies.
	logic [STEPS_W-1:0]  steps_reg;
	logic [RADIAL_W-1:0] radial_reg;
	logic [MW-1:0]       avg_thr;
	logic [MW-1:0]       max_thr;
	logic [MW-1:0]       part_thr;

	// Grid walk state.
	logic [MW-1:0]       line_store [0:MAX_RADIAL];
	logic [MW-1:0]       left_m;
	logic [MW-1:0]       upleft_m;
	logic [RADIAL_W-1:0] col_cnt;
	logic [STEPS_W-1:0]  row_cnt;
	vidx_t               vtx_cnt;
	bit                  wrapped;

	task automatic flag_mismatch(input string msg);
		fail_count++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Advances the grid walk by one vertex, unless the grid is finished, and
	// queues the six corners of the quad it closes, unless the quad is culled.
	task automatic triangulate_vertex(input logic [MW-1:0] raw_mask, input logic fresh_grid);
		int unsigned steps_eff, radial_eff, col, sum, peak;
		logic [MW-1:0] m, above;
		vidx_t d, c, b, a;
		corner_t e;
		bit cull;
		int k;
		steps_eff = (steps_reg < MIN_STEPS) ? MIN_STEPS :
			(steps_reg > MAX_STEPS) ? MAX_STEPS : steps_reg;
		radial_eff = (radial_reg < MIN_RADIAL) ? MIN_RADIAL :
			(radial_reg > MAX_RADIAL) ? MAX_RADIAL : radial_reg;
		m = (raw_mask > MASK_ONE) ? MW'(MASK_ONE) : raw_mask;
		if (fresh_grid) begin
			col_cnt = '0;
			row_cnt = '0;
			vtx_cnt = '0;
		end
		// A finished grid swallows samples until the next grid start.
		if (row_cnt > steps_eff) begin
			ignored_vertices++;
			return;
		end
		col = (col_cnt > radial_eff) ? radial_eff : 32'(col_cnt);
		above = line_store[col[LSW-1:0]];
		if (row_cnt != 0 && col != 0) begin
			sum = 32'(upleft_m) + 32'(above) + 32'(left_m) + 32'(m);
			peak = 32'(upleft_m);
			if (above > peak) peak = 32'(above);
			if (left_m > peak) peak = 32'(left_m);
			if (m > peak) peak = 32'(m);
			cull = (sum > 4 * avg_thr) || (peak > max_thr && sum > 4 * part_thr);
			if (cull) begin
				culled_quads++;
			end else begin
				kept_quads++;
				d = vtx_cnt;
				c = d - IDX_W'(1);
				b = d - IDX_W'(radial_eff + 1);
				a = b - IDX_W'(1);
				// Corner order is a, c, b, b, c, d.
				for (k = 0; k < 6; k++) begin
					e.idx = (k == 0) ? a : (k == 1 || k == 4) ? c : (k == 5) ? d : b;
					e.last = (k == 5);
					expected_corners = {expected_corners, e};
				end
			end
		end
		upleft_m = above;
		line_store[col[LSW-1:0]] = m;
		left_m = m;
		vtx_cnt = vtx_cnt + IDX_W'(1);
		if (col >= radial_eff) begin
			col_cnt = '0;
			row_cnt = row_cnt + STEPS_W'(1);
			if (row_cnt > steps_eff + 1) row_cnt = STEPS_W'(steps_eff + 1);
		end else begin
			col_cnt = RADIAL_W'(col + 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_corners.delete();
			steps_reg = STEPS_W'(STEPS_AT_RESET);
			radial_reg = RADIAL_W'(RADIAL_AT_RESET);
			avg_thr = MW'(AVG_AT_RESET);
			max_thr = MW'(MAX_AT_RESET);
			part_thr = MW'(PART_AT_RESET);
			line_store = '{default: '0};
			left_m = '0;
			upleft_m = '0;
			col_cnt = '0;
			row_cnt = '0;
			vtx_cnt = '0;
			wrapped = 1'b0;
			fail_count = 0;
			kept_quads = 0;
			culled_quads = 0;
			ignored_vertices = 0;
			indices_checked = 0;
			outstanding <= 0;
		end else begin
			// An index cannot leave in the cycle its vertex arrives, so the
			// output side is checked before the new vertex is predicted.
			if (out_valid && out_ready) begin
				if (expected_corners.size() == 0) begin
					flag_mismatch($sformatf("index %0d arrived with no quad pending",
						vertex_index));
				end else begin
					want = expected_corners.pop_front();
					indices_checked++;
					if (vertex_index !== want.idx)
						flag_mismatch($sformatf("vertex_index %0d, expected %0d",
							vertex_index, want.idx));
					if (last_of_quad !== want.last)
						flag_mismatch($sformatf("last_of_quad %b, expected %b at index %0d",
							last_of_quad, want.last, want.idx));
				end
			end
			if (cfg_write_en) begin
				case (cfg_index)
					REG_STEPS:    steps_reg = cfg_data[STEPS_W-1:0];
					REG_RADIAL:   radial_reg = cfg_data[RADIAL_W-1:0];
					REG_AVG_THR:  avg_thr = cfg_data[MW-1:0];
					REG_MAX_THR:  max_thr = cfg_data[MW-1:0];
					REG_PART_THR: part_thr = cfg_data[MW-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				triangulate_vertex(opening_mask, grid_start);
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				while (expected_corners.size() != 0) begin
					want = expected_corners.pop_front();
					flag_mismatch($sformatf("index %0d never arrived", want.idx));
				end
			end
			outstanding <= expected_corners.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Masked grid triangulator testbench
// Drives vertex mask requests over several grid geometries and threshold
// settings, with random gaps and output stalls, and lets the checker compare
// every emitted triangle index against its own prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import mgt_pkg::*;

	localparam int MASK_FRAC_BITS = 12;
	localparam int MW             = MASK_FRAC_BITS + 1;
	localparam int CFG_W          = (MW > STEPS_W) ? MW : STEPS_W;
	localparam int MASK_ONE       = 1 << MASK_FRAC_BITS;

	// Culled vertices need no time in the back end, so SETTLE_CYCLES covers anything in flight.
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	// Long enough for the four-entry quad queue and the output register to
	// fill while the sender keeps offering requests.
	localparam int HOLD_CYCLES   = 300;
	// The slowest legal run is a few hundred requests, each with six indices
	// behind random output stalls; this is well above that.
	localparam int LIMIT_CYCLES  = 200000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write_en = 1'b0;
	cfg_reg_t         cfg_index = REG_STEPS;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [MW-1:0]    opening_mask = '0;
	logic             grid_start = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [IDX_W-1:0] vertex_index;
	logic             last_of_quad;

	logic             wrap_up = 1'b0;
	int               outstanding;
	int               fail_count;
	int               kept_quads;
	int               culled_quads;
	int               ignored_vertices;
	int               indices_checked;

	// hold_off_req and calm are shared between the stimulus and the receiver process.
	bit               hold_off_req = 1'b0;
	bit               calm = 1'b0;
	int               sent_vertices = 0;
	int               settings_used = 0;
	int               cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	masked_grid_triangulator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opening_mask (opening_mask),
		.grid_start   (grid_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vertex_index (vertex_index),
		.last_of_quad (last_of_quad)
	);

	mgt_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_en     (cfg_write_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opening_mask     (opening_mask),
		.grid_start       (grid_start),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.vertex_index     (vertex_index),
		.last_of_quad     (last_of_quad),
		.wrap_up          (wrap_up),
		.outstanding      (outstanding),
		.fail_count       (fail_count),
		.kept_quads       (kept_quads),
		.culled_quads     (culled_quads),
		.ignored_vertices (ignored_vertices),
		.indices_checked  (indices_checked)
	);

	// Writes all five registers on consecutive edges. The write enable is
	// raised once and dropped once, so it never sees two assignments in the
	// same step.
	task automatic program_regs(input int unsigned steps, input int unsigned radial,
			input int unsigned avg, input int unsigned peak, input int unsigned part);
		cfg_write_en <= 1'b1;
		cfg_index <= REG_STEPS;
		cfg_data <= CFG_W'(steps);
		@(posedge clk);
		cfg_index <= REG_RADIAL;
		cfg_data <= CFG_W'(radial);
		@(posedge clk);
		cfg_index <= REG_AVG_THR;
		cfg_data <= CFG_W'(avg);
		@(posedge clk);
		cfg_index <= REG_MAX_THR;
		cfg_data <= CFG_W'(peak);
		@(posedge clk);
		cfg_index <= REG_PART_THR;
		cfg_data <= CFG_W'(part);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		settings_used++;
	endtask

	// Offers one vertex request and returns at the edge where it is taken.
	// A random gap may come first; valid is then held until acceptance.
	task automatic push_vertex(input logic [MW-1:0] m, input logic s);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opening_mask <= m;
		grid_start <= s;
		do @(posedge clk); while (!in_ready);
		sent_vertices++;
	endtask

	// Mostly small masks so that quads survive the cull, with full-scale,
	// saturating and all-bits values mixed in.
	function automatic logic [MW-1:0] pick_mask(input int unsigned zero_pct);
		if ($urandom_range(0, 99) < zero_pct) return '0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return MW'($urandom_range(0, 1200));
			6, 7:             return MW'($urandom_range(0, MASK_ONE));
			8:                return MW'($urandom_range(0, (1 << MW) - 1));
			default:          return ($urandom_range(0, 1) != 0) ? MW'(MASK_ONE) : '0;
		endcase
	endfunction

	// Sends n random vertices. The first one opens a new grid when fresh is
	// set; with noise on, a stray grid start now and then breaks the walk.
	task automatic run_phase(input int n, input bit fresh, input int unsigned zero_pct,
			input bit noise);
		bit s;
		for (int i = 0; i < n; i++) begin
			s = (i == 0) ? fresh : (noise && $urandom_range(0, 39) == 0);
			push_vertex(pick_mask(zero_pct), s);
		end
	endtask

	// Drops valid and waits until every predicted index has come out, then
	// lets any culled vertex still inside the block drain.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stall bursts, one long hold-off on request, and no
	// stalls at all once the stimulus turns calm.
	initial begin : drain
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped at the cycle limit with %0d indices outstanding", outstanding);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned corner_masks [0:28];
		// Row 0 brings zero, full scale and an oversized mask; row 1 closes
		// quads that are kept, culled by the average rule and culled by the
		// high-corner rule; row 2 ends the grid, and the last two samples
		// arrive after the grid is finished and must be ignored.
		corner_masks = '{0, 0, MASK_ONE, 8191, 1000, 1000, 3000, 0, 100,
			0, 0, 600, 0, 8191, 1000, 0, 0, 3000,
			4095, 1, 2048, MASK_ONE, 0, 1234, 7000, 5, 0,
			MASK_ONE, 0};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed grid at the smallest geometry and the default thresholds.
		program_regs(2, 8, 1720, 3031, 1147);
		for (int i = 0; i < 29; i++) push_vertex(MW'(corner_masks[i]), i == 0);
		settle();

		// Thresholds at 1.0 keep every quad; the receiver holds off for a
		// long stretch here so the queue fills and input backs up.
		program_regs(2, 12, MASK_ONE, MASK_ONE, MASK_ONE);
		hold_off_req = 1'b1;
		run_phase(27, 1'b1, 0, 1'b1);
		settle();

		// Zero geometry saturates to the minimum grid; zero thresholds cull
		// everything but all-zero quads, so masks lean heavily on zero.
		program_regs(0, 0, 0, 0, 0);
		run_phase(20, 1'b1, 70, 1'b1);
		settle();

		// Steps below the floor with an odd radial segment count and a mixed cull.
		program_regs(1, 9, 1000, 2000, 600);
		run_phase(22, 1'b1, 30, 1'b1);
		settle();

		// Oversized geometry saturates to the largest grid; only row 0 and
		// part of row 1 are sent. The average threshold sits at its top.
		program_regs(4095, 255, 8191, 2500, 900);
		run_phase(140, 1'b1, 10, 1'b0);
		settle();

		// Shrink the geometry in the middle of that grid: the walk carries on
		// without a grid start, the current row ends at the new last column,
		// and samples after the last row are ignored.
		program_regs(3, 10, 2200, 3500, 1500);
		run_phase(26, 1'b0, 10, 1'b0);
		settle();

		// Closing stretch at the default thresholds with no idling.
		calm = 1'b1;
		program_regs(2, 8, 1720, 3031, 1147);
		run_phase(27, 1'b1, 0, 1'b1);
		settle();

		repeat (TAIL_CYCLES) @(posedge clk);
		wrap_up <= 1'b1;
		repeat (3) @(posedge clk);

		$display("Drove %0d vertex requests under %0d register settings, %0d of them ignored",
			sent_vertices, settings_used, ignored_vertices);
		$display("Compared %0d indices from %0d kept quads; %0d quads culled",
			indices_checked, kept_quads, culled_quads);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
